/* rtl/oal_pkg.sv */
package oal_pkg;

    // list geometry
    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 64;
    localparam int SHOW_CAP  = 16;

    // fixed field widths of the channels
    localparam int CMD_W  = 3;
    localparam int KEYV_W = 64;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int EIDX_W = 4;
    localparam int ECNT_W = 5;

    // derived widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_SHOW   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             en;
        t_cmd             op;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] cnt;
        t_key             key;
    } t_cell_ctl;

endpackage

/* rtl/oal_if.sv */
// command channel
interface oal_cmd_if;
    import oal_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [KEYV_W-1:0] key_value;
    logic [POS_W-1:0]  position;

    modport source (output valid, command, key_value, position, input ready);
    modport sink   (input valid, command, key_value, position, output ready);
    modport monitor (input valid, ready, command, key_value, position);
endinterface

// result channel
interface oal_res_if;
    import oal_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [EIDX_W-1:0] entry_index;
    logic [KEYV_W-1:0] entry_value;
    logic [ECNT_W-1:0] entry_count;
    logic              last;

    modport source (output valid, status, entry_index, entry_value, entry_count, last,
                    input ready);
    modport sink   (input valid, status, entry_index, entry_value, entry_count, last,
                    output ready);
    modport monitor (input valid, ready, status, entry_index, entry_value, entry_count,
                     last);
endinterface

/* rtl/oal_cell.sv */
module oal_cell (
    input  logic                     i_clk,
    input  oal_pkg::t_cell_ctl       i_ctl,
    input  logic [oal_pkg::CMP_W-1:0] i_idx,
    input  oal_pkg::t_key            i_left,
    input  oal_pkg::t_key            i_right,
    output oal_pkg::t_key            o_entry,
    output logic                     o_match
);
    import oal_pkg::*;

    t_key r_entry;
    t_key n_entry;
    logic n_load;

    // pick the new content: own key, left neighbour (insert) or right neighbour (remove)
    always_comb begin
        n_load  = 1'b0;
        n_entry = r_entry;
        if (i_ctl.en) begin
            case (i_ctl.op)
                CMD_APPEND: begin
                    if (i_idx == i_ctl.cnt) begin
                        n_load  = 1'b1;
                        n_entry = i_ctl.key;
                    end
                end
                CMD_INSERT: begin
                    if (i_idx == i_ctl.pos) begin
                        n_load  = 1'b1;
                        n_entry = i_ctl.key;
                    end else if (i_idx > i_ctl.pos && i_idx <= i_ctl.cnt) begin
                        n_load  = 1'b1;
                        n_entry = i_left;
                    end
                end
                CMD_REMOVE: begin
                    if (i_idx >= i_ctl.pos && (i_idx + CMP_W'(1)) < i_ctl.cnt) begin
                        n_load  = 1'b1;
                        n_entry = i_right;
                    end
                end
                default: begin
                    n_load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_entry <= n_entry;
        end
    end

    // match only counts for occupied slots
    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctl.key) && (i_idx < i_ctl.cnt);

endmodule

/* rtl/oal_chain.sv */
module oal_chain (
    input  logic                       i_clk,
    input  oal_pkg::t_cell_ctl         i_ctl,
    output oal_pkg::t_key              o_entries [oal_pkg::DEPTH],
    output logic [oal_pkg::DEPTH-1:0]  o_match
);
    import oal_pkg::*;

    t_key w_left  [DEPTH];
    t_key w_right [DEPTH];

    // neighbour wiring; the ends see zero
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_mid_l
                assign w_left[g] = o_entries[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right[g] = '0;
            end else begin : g_mid_r
                assign w_right[g] = o_entries[g+1];
            end

            oal_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_idx   (CMP_W'(g)),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_entry (o_entries[g]),
                .o_match (o_match[g])
            );
        end
    endgenerate

endmodule

/* rtl/ordered_array_list_engine_top.sv */
// Channel   Dir  Fields                                              Handshake
// i_cmd     in   command, key_value, position                        valid/ready
// o_res     out  status, entry_index, entry_value, entry_count, last valid/ready
//
// Append, insert, remove and search complete in the cycle they are accepted; the
// cell chain shifts and compares all entries at once. Show gives one word per cycle
// unless a result stalls, min(count, 16) words, paced by the single output register.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
// A stalled result holds i_cmd.ready low; no new command is taken until it moves.
module ordered_array_list_engine_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_cmd_if.sink   i_cmd,
    oal_res_if.source o_res
);
    import oal_pkg::*;

    typedef enum logic {S_IDLE, S_SHOW} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CMP_W-1:0] r_ptr;
    logic [CMP_W-1:0] r_nshow;
    logic             r_ov;
    t_status          r_status;
    logic [EIDX_W-1:0] r_eidx;
    t_key             r_eval;
    logic [ECNT_W-1:0] r_ecnt;
    logic             r_last;

    t_state           n_state;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] n_ptr;
    logic [CMP_W-1:0] n_nshow;
    logic             n_load;
    t_status          n_status;
    logic [CMP_W-1:0] n_eidx;
    t_key             n_eval;
    logic             n_last;

    t_cell_ctl        w_ctl;
    t_key             w_entries [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic             w_free;
    logic             w_acc;
    t_cmd             w_cmd;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_nshow;
    logic [CMP_W-1:0] w_found;
    logic             w_any;
    logic [IDX_W-1:0] w_rd;

    // handshake
    assign w_free      = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_free;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    assign w_cmd   = t_cmd'(i_cmd.command);
    assign w_cnt   = CMP_W'(r_count);
    assign w_pos   = CMP_W'(i_cmd.position);
    assign w_nshow = (w_cnt > CMP_W'(SHOW_CAP)) ? CMP_W'(SHOW_CAP) : w_cnt;
    assign w_rd    = (r_state == S_SHOW) ? r_ptr[IDX_W-1:0] : '0;

    oal_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .o_entries (w_entries),
        .o_match   (w_match)
    );

    // first matching slot
    always_comb begin
        w_found = '0;
        w_any   = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found = CMP_W'(i);
                w_any   = 1'b1;
            end
        end
    end

    // command decode and result formation
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_nshow    = r_nshow;
        n_load     = 1'b0;
        n_status   = ST_OK;
        n_eidx     = '0;
        n_eval     = '0;
        n_last     = 1'b1;
        w_ctl.en   = 1'b0;
        w_ctl.op   = w_cmd;
        w_ctl.pos  = w_pos;
        w_ctl.cnt  = w_cnt;
        w_ctl.key  = i_cmd.key_value[KEY_WIDTH-1:0];

        if (r_state == S_SHOW) begin
            if (w_free) begin
                n_load = 1'b1;
                n_eidx = r_ptr;
                n_eval = w_entries[w_rd];
                n_last = (r_ptr + CMP_W'(1)) == r_nshow;
                n_ptr  = r_ptr + CMP_W'(1);
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
        end else if (w_acc) begin
            n_load = 1'b1;
            case (w_cmd)
                CMD_APPEND: begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.en = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_SEARCH: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_any) begin
                        n_eidx = w_found;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                CMD_REMOVE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_pos >= w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_ctl.en = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                CMD_INSERT: begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else if (w_pos > w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_ctl.en = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_SHOW: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_eval  = w_entries[w_rd];
                        n_last  = (w_nshow == CMP_W'(1));
                        n_nshow = w_nshow;
                        n_ptr   = CMP_W'(1);
                        if (!n_last) begin
                            n_state = S_SHOW;
                        end
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // state, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
        r_ptr   <= n_ptr;
        r_nshow <= n_nshow;
        if (n_load) begin
            r_status <= n_status;
            r_eidx   <= n_eidx[EIDX_W-1:0];
            r_eval   <= n_eval;
            r_ecnt   <= ECNT_W'(n_count);
            r_last   <= n_last;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_status;
    assign o_res.entry_index = r_eidx;
    assign o_res.entry_value = KEYV_W'(r_eval);
    assign o_res.entry_count = r_ecnt;
    assign o_res.last        = r_last;

endmodule

/* rtl/oal_checker.sv */
module oal_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [oal_pkg::STAT_W-1:0]    i_res_status,
    input logic [oal_pkg::EIDX_W-1:0]    i_res_entry_index,
    input logic [oal_pkg::ECNT_W-1:0]    i_res_entry_count,
    input logic                          i_res_last
);
    import oal_pkg::*;

    // nothing pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result word present after reset");

    // a waiting result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result word dropped while stalled");

    // no command taken while a result is stalled
    a_no_acc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_cmd_ready)
        else $error("command taken while result stalled");

    // a show burst runs without gaps through consecutive indices
    a_show_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_res_last |=>
            i_res_valid && (i_res_status == ST_OK) &&
            (i_res_entry_index == EIDX_W'($past(i_res_entry_index) + 1'b1)))
        else $error("show burst broken");

    // count never beyond capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_entry_count <= ECNT_W'(DEPTH)))
        else $error("entry count beyond capacity");

endmodule

bind ordered_array_list_engine_top oal_checker u_oal_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_entry_index (o_res.entry_index),
    .i_res_entry_count (o_res.entry_count),
    .i_res_last        (o_res.last)
);
